/* design/dfbp_pkg.sv */
// Shared types and constants for the five-bit dictionary code packer.
// No dependencies; every design file refers to it by scoped names.
package dfbp_pkg;

  localparam int KEY_ENTRIES_DEFAULT = 31;
  localparam int CODE_BITS           = 5;
  localparam int KEY_CHARS_MAX       = 31;

  localparam logic [CODE_BITS-1:0] END_CODE = 5'h1F;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam int ADDR_W = 6;
  localparam int DATA_W = 64;

  typedef enum logic {
    REQ_CHAR = 1'b0,
    REQ_END  = 1'b1
  } req_t;

  typedef enum logic [2:0] {
    REG_KEY_LOW      = 3'd0,
    REG_KEY_MID_LOW  = 3'd1,
    REG_KEY_MID_HIGH = 3'd2,
    REG_KEY_HIGH     = 3'd3,
    REG_KEY_LENGTH   = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    req_t       req_type;
    logic [7:0] char_in;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
    logic       unmatched_seen;
  } out_word_t;

  typedef struct packed {
    req_t                 req_type;
    logic [CODE_BITS-1:0] code;
    logic                 miss;
  } qentry_t;

  typedef struct packed {
    logic [QPTR_W:0] count;
    logic            full;
    logic            not_empty;
  } queue_status_t;

  typedef struct packed {
    logic       second_pend;
    logic       miss;
    logic [2:0] pending_count;
  } back_status_t;

endpackage

/* design/dfbp_front.sv */
// Front end: key registers on the APB port and the parallel key lookup.
// Classifies each accepted word into a queue entry. Uses dfbp_pkg.
module dfbp_front #(
  parameter int KEY_ENTRIES = dfbp_pkg::KEY_ENTRIES_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  dfbp_pkg::in_word_t          in_word,
  input  dfbp_pkg::queue_status_t     q_status,
  output logic                        push,
  output dfbp_pkg::qentry_t           push_entry,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dfbp_pkg::ADDR_W-1:0] paddr,
  input  logic [dfbp_pkg::DATA_W-1:0] pwdata,
  output logic [dfbp_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  logic [63:0] key_low;
  logic [63:0] key_mid_low;
  logic [63:0] key_mid_high;
  logic [55:0] key_high;
  logic [4:0]  key_length;

  logic [8*dfbp_pkg::KEY_CHARS_MAX-1:0] key_flat;
  dfbp_pkg::cfg_reg_t                   reg_sel;
  logic                                 found;
  logic [dfbp_pkg::CODE_BITS-1:0]       code;

  assign pready  = 1'b1;
  assign reg_sel = dfbp_pkg::cfg_reg_t'(paddr[5:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low      <= '0;
      key_mid_low  <= '0;
      key_mid_high <= '0;
      key_high     <= '0;
      key_length   <= '0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        dfbp_pkg::REG_KEY_LOW:      key_low      <= pwdata;
        dfbp_pkg::REG_KEY_MID_LOW:  key_mid_low  <= pwdata;
        dfbp_pkg::REG_KEY_MID_HIGH: key_mid_high <= pwdata;
        dfbp_pkg::REG_KEY_HIGH:     key_high     <= pwdata[55:0];
        dfbp_pkg::REG_KEY_LENGTH:   key_length   <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      dfbp_pkg::REG_KEY_LOW:      prdata = key_low;
      dfbp_pkg::REG_KEY_MID_LOW:  prdata = key_mid_low;
      dfbp_pkg::REG_KEY_MID_HIGH: prdata = key_mid_high;
      dfbp_pkg::REG_KEY_HIGH:     prdata = {8'h00, key_high};
      dfbp_pkg::REG_KEY_LENGTH:   prdata = {59'd0, key_length};
      default:                    prdata = '0;
    endcase
  end

  assign key_flat = {key_high, key_mid_high, key_mid_low, key_low};

  // lowest matching position wins
  always_comb begin
    found = 1'b0;
    code  = dfbp_pkg::END_CODE;
    for (int i = KEY_ENTRIES - 1; i >= 0; i--) begin
      if (key_flat[8*i +: 8] == in_word.char_in && 5'(i) < key_length) begin
        found = 1'b1;
        code  = 5'(i);
      end
    end
  end

  assign in_stall            = q_status.full;
  assign push                = in_valid && !q_status.full;
  assign push_entry.req_type = in_word.req_type;
  assign push_entry.code     = code;
  assign push_entry.miss     = (in_word.req_type == dfbp_pkg::REQ_CHAR) && !found;

endmodule

/* design/dfbp_queue.sv */
// Short queue of classified entries between front and back ends.
// Register array with wrapping pointers. Uses dfbp_pkg.
module dfbp_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  dfbp_pkg::qentry_t       push_entry,
  input  logic                    pop,
  output dfbp_pkg::qentry_t       head,
  output dfbp_pkg::queue_status_t status
);

  dfbp_pkg::qentry_t entries [dfbp_pkg::QUEUE_DEPTH];

  logic [dfbp_pkg::QPTR_W-1:0] wr_ptr;
  logic [dfbp_pkg::QPTR_W-1:0] rd_ptr;
  logic [dfbp_pkg::QPTR_W:0]   count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_entry;
  end

  assign head             = entries[rd_ptr];
  assign status.count     = count;
  assign status.full      = (count == (dfbp_pkg::QPTR_W+1)'(dfbp_pkg::QUEUE_DEPTH));
  assign status.not_empty = (count != '0);

endmodule

/* design/dfbp_back.sv */
// Back end: packs 5-bit codes MSB first into bytes, handles end flush,
// and holds the output register. Uses dfbp_pkg.
module dfbp_back (
  input  logic                    clk,
  input  logic                    rst,
  input  dfbp_pkg::qentry_t       head,
  input  dfbp_pkg::queue_status_t q_status,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output dfbp_pkg::out_word_t     out_word,
  output dfbp_pkg::back_status_t  status
);

  logic [6:0] pending_bits, pending_bits_next;
  logic [2:0] pending_count, pending_count_next;
  logic       miss_flag, miss_flag_next;
  logic       second_pend, second_pend_next;
  logic [7:0] second_byte, second_byte_next;
  logic       out_valid_next;
  dfbp_pkg::out_word_t out_word_next;

  logic                           can_load;
  logic [dfbp_pkg::CODE_BITS-1:0] code;
  logic [11:0]                    wide;
  logic [3:0]                     total;
  logic [2:0]                     rem;
  logic [15:0]                    aligned;
  logic [11:0]                    keep;
  logic                           miss_new;

  assign can_load = !out_valid || !out_stall;

  always_comb begin
    code     = (head.req_type == dfbp_pkg::REQ_END) ? dfbp_pkg::END_CODE : head.code;
    wide     = {pending_bits, code};
    total    = {1'b0, pending_count} + 4'(dfbp_pkg::CODE_BITS);
    rem      = 3'(total - 4'd8);
    aligned  = {4'b0000, wide} << (5'd16 - {1'b0, total});
    keep     = wide & ((12'd1 << rem) - 12'd1);
    miss_new = miss_flag | head.miss;
  end

  always_comb begin
    pop                = 1'b0;
    pending_bits_next  = pending_bits;
    pending_count_next = pending_count;
    miss_flag_next     = miss_flag;
    second_pend_next   = second_pend;
    second_byte_next   = second_byte;
    out_valid_next     = out_valid;
    out_word_next      = out_word;
    if (can_load) begin
      out_valid_next = 1'b0;
      if (second_pend) begin
        out_valid_next   = 1'b1;
        out_word_next    = '{out_byte: second_byte, last_byte: 1'b1,
                             unmatched_seen: miss_flag};
        second_pend_next = 1'b0;
      end else if (q_status.not_empty) begin
        pop = 1'b1;
        if (head.req_type == dfbp_pkg::REQ_CHAR) begin
          miss_flag_next = miss_new;
          if (total >= 4'd8) begin
            out_valid_next     = 1'b1;
            out_word_next      = '{out_byte: aligned[15:8], last_byte: 1'b0,
                                   unmatched_seen: miss_new};
            pending_bits_next  = keep[6:0];
            pending_count_next = rem;
          end else begin
            pending_bits_next  = wide[6:0];
            pending_count_next = total[2:0];
          end
        end else begin
          pending_bits_next  = '0;
          pending_count_next = '0;
          out_valid_next     = 1'b1;
          if (total <= 4'd8) begin
            out_word_next = '{out_byte: aligned[15:8], last_byte: 1'b1,
                              unmatched_seen: miss_flag};
          end else begin
            out_word_next    = '{out_byte: aligned[15:8], last_byte: 1'b0,
                                 unmatched_seen: miss_flag};
            second_pend_next = 1'b1;
            second_byte_next = aligned[7:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_bits  <= '0;
      pending_count <= '0;
      miss_flag     <= 1'b0;
      second_pend   <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      pending_bits  <= pending_bits_next;
      pending_count <= pending_count_next;
      miss_flag     <= miss_flag_next;
      second_pend   <= second_pend_next;
      out_valid     <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    second_byte <= second_byte_next;
    out_word    <= out_word_next;
  end

  assign status.second_pend   = second_pend;
  assign status.miss          = miss_flag;
  assign status.pending_count = pending_count;

endmodule

/* design/dictionary_five_bit_packer.sv */
// Top level of the five-bit dictionary code packer: front lookup, queue, back packer.
// Depends on dfbp_pkg, dfbp_front, dfbp_queue and dfbp_back.
//
//   channel  direction  handshake          payload
//   in       input      in_valid/in_stall   in_word   (req_type, char_in)
//   out      output     out_valid/out_stall out_word  (out_byte, last_byte, unmatched_seen)
//   cfg      input      psel/penable/pready paddr, pwdata, prdata (64-bit registers at 8*i)
//
// One word per cycle in while the queue is not full; the lookup is combinational parallel
// compares into a 4-entry queue. The packer retires one entry per cycle unless out_stall
// holds it or an end word's second byte is pending; output bytes are registered.
// Synchronous reset clears key registers, queue pointers, packer state and the miss flag.
// out_stall holds the output register and backs up the queue; in_stall is queue full.
module dictionary_five_bit_packer #(
  parameter int KEY_ENTRIES = dfbp_pkg::KEY_ENTRIES_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  dfbp_pkg::in_word_t          in_word,
  output logic                        out_valid,
  input  logic                        out_stall,
  output dfbp_pkg::out_word_t         out_word,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dfbp_pkg::ADDR_W-1:0] paddr,
  input  logic [dfbp_pkg::DATA_W-1:0] pwdata,
  output logic [dfbp_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  logic                    push;
  logic                    pop;
  dfbp_pkg::qentry_t       push_entry;
  dfbp_pkg::qentry_t       head;
  dfbp_pkg::queue_status_t q_status;
  dfbp_pkg::back_status_t  b_status;

  dfbp_front #(
    .KEY_ENTRIES(KEY_ENTRIES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .q_status   (q_status),
    .push       (push),
    .push_entry (push_entry),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  dfbp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  dfbp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .status    (b_status)
  );

  // a held second byte always has its first byte in the output register
  a_second_has_first: assert property (@(posedge clk) disable iff (rst)
    b_status.second_pend |-> out_valid && !out_word.last_byte)
    else $error("second flush byte held without first byte on output");

  // a final byte on the output means the packer has been emptied
  a_last_empties: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.last_byte |-> b_status.pending_count == 3'd0 && !b_status.second_pend)
    else $error("packer not empty while final byte is shown");

  // miss flag only clears on reset
  a_miss_sticky: assert property (@(posedge clk) disable iff (rst)
    b_status.miss |=> b_status.miss)
    else $error("miss flag cleared without reset");

  // the queue never pops while empty nor exceeds its depth
  a_queue_bounds: assert property (@(posedge clk) disable iff (rst)
    (pop |-> q_status.not_empty) &&
    (q_status.count <= (dfbp_pkg::QPTR_W+1)'(dfbp_pkg::QUEUE_DEPTH)))
    else $error("queue pointer bookkeeping broken");

endmodule
